### rtl/core/ffx_pkg.sv
// ----------------------------------------------------------------------------
// ffx_pkg
// Shared constants, types and helpers for the form field extractor.
// ----------------------------------------------------------------------------
package ffx_pkg;

  // longest key the prefix matcher supports
  localparam int MAX_KEY_LEN = 32;
  // key characters held in the key registers
  localparam int KEY_CHARS   = 32;
  localparam int KEY_BITS    = KEY_CHARS * 8;

  // at most three decoded bytes come out of one body byte
  localparam int EMIT_MAX    = 3;
  localparam int EMIT_CNT_W  = $clog2(EMIT_MAX + 1);

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_CHARS_0 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_CHARS_1 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_CHARS_2 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_CHARS_3 = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_VALUE_LIMIT = 3'd5;

  localparam logic [7:0] VALUE_LIMIT_RST = 8'd255;

  // special characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // one queue entry: the decoded bytes caused by one body byte
  typedef struct packed {
    logic [EMIT_CNT_W-1:0]     cnt;
    logic [EMIT_MAX-1:0][7:0]  byt;
    logic                      last;
    logic                      found;
  } ffx_ev_t;

  // append a byte to an entry, extra bytes beyond the limit are dropped
  function automatic ffx_ev_t ev_add(ffx_ev_t e, logic [7:0] v);
    ffx_ev_t r;
    r = e;
    if (e.cnt != EMIT_CNT_W'(EMIT_MAX)) begin
      r.byt[e.cnt[1:0]] = v;
      r.cnt = e.cnt + EMIT_CNT_W'(1);
    end
    return r;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
    end else begin
      d = c - 8'h37;
    end
    return d[3:0];
  endfunction

endpackage

### rtl/core/form_field_extract_url_decode.sv
// ----------------------------------------------------------------------------
// form_field_extract_url_decode
// Finds the first "key=" in a form body and streams out the URL-decoded value.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              contents
//  in_*         in   in_tvalid/in_tready    tdata: byte of the body; tlast: end
//  out_*        out  out_tvalid/out_tready  tdata: decoded byte; tlast: final
//                                           tuser: [0] byte valid, [1] found
//  cfg_*        in   cfg_we                 register index and write data
//
//  one body byte per cycle; each byte gives zero to three result words, the
//  back end sends one word per cycle, so bursts of escapes slow input only
//  when the four-entry queue between front and back fills up
//  input to first result word: through the queue entry, then the output register
//  reset is synchronous and clears state, queue and output; no clearing pass
//  an output stall holds the word and lets the queue fill before in_tready drops
// ----------------------------------------------------------------------------
module form_field_extract_url_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [ffx_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ffx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // body input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] in_byte
  input  logic                            in_tlast,
  // decoded output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] out_byte
  output logic                            out_tlast,
  output logic [1:0]                      out_tuser   // [0] out_valid, [1] found
);
  import ffx_pkg::*;

  logic    acc;
  logic    ev_push;
  ffx_ev_t ev;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  ffx_ev_t q_head;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  // search, capture and decode
  ffx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .ev_push   (ev_push),
    .ev        (ev)
  );

  // decoupling queue
  ffx_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_push),
    .push_ev (ev),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  // word serializer and output stage
  ffx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/core/ffx_front.sv
// ----------------------------------------------------------------------------
// ffx_front
// Accepts body bytes, runs the key search, value capture and percent
// decoding, and hands the decoded bytes of each body byte to the queue.
// ----------------------------------------------------------------------------
module ffx_front (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [ffx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ffx_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // body bytes
  input  logic                              acc,
  input  logic [7:0]                        in_byte,
  input  logic                              in_last,
  // to queue
  output logic                              ev_push,
  output ffx_pkg::ffx_ev_t                  ev
);
  import ffx_pkg::*;

  typedef enum logic [1:0] {PH_SEARCH, PH_CAPTURE, PH_SKIP} phase_t;
  typedef enum logic [1:0] {DEC_IDLE, DEC_PCT, DEC_PCT_HEX} dec_t;

  // configuration registers
  logic [5:0]          key_len_r;
  logic [KEY_BITS-1:0] key_chars_r;
  logic [7:0]          limit_r;

  // body state; pfx_r[i] set when the last i bytes equal the first i key chars
  logic [MAX_KEY_LEN:0] pfx_r, pfx_nxt;
  phase_t               phase_r, phase_nxt;
  logic [7:0]           raw_r, raw_nxt;
  dec_t                 dec_r, dec_nxt;
  logic [7:0]           held_r, held_nxt;

  logic [MAX_KEY_LEN-1:0] eqv;
  logic [MAX_KEY_LEN:0]   stop, first_stop;
  logic                   match;
  logic                   body_end;
  logic                   step_dec;
  logic                   flush_amp;
  ffx_ev_t                e;

  function automatic logic [7:0] key_char(logic [KEY_BITS-1:0] kc, int i);
    if (i >= KEY_CHARS) begin
      return CH_NUL;
    end
    return kc[i*8 +: 8];
  endfunction

  // per-position compare and key end: first zero char or key length
  always_comb begin
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      eqv[i]  = (in_byte == key_char(key_chars_r, i));
      stop[i] = (key_char(key_chars_r, i) == CH_NUL) ||
                (7'(i) >= {1'b0, key_len_r});
    end
    stop[MAX_KEY_LEN] = 1'b1;
  end

  // isolate the lowest set stop bit: the effective key length
  assign first_stop = stop & (~stop + (MAX_KEY_LEN+1)'(1));
  assign match      = (in_byte == CH_EQ) && (|(pfx_r & first_stop));
  assign body_end   = in_last || (in_byte == CH_NUL);

  // next state and decoded bytes for this body byte
  always_comb begin
    pfx_nxt   = pfx_r;
    phase_nxt = phase_r;
    raw_nxt   = raw_r;
    dec_nxt   = dec_r;
    held_nxt  = held_r;
    step_dec  = 1'b0;
    flush_amp = 1'b0;
    e         = '0;

    if (in_byte != CH_NUL) begin
      case (phase_r)
        PH_SEARCH: begin
          pfx_nxt = {pfx_r[MAX_KEY_LEN-1:0] & eqv, 1'b1};
          if (match) begin
            phase_nxt = PH_CAPTURE;
          end
        end
        PH_CAPTURE: begin
          if (in_byte == CH_AMP) begin
            flush_amp = 1'b1;
            phase_nxt = PH_SKIP;
          end else if (raw_r < limit_r) begin
            raw_nxt  = raw_r + 8'd1;
            step_dec = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // pending escape cut off by '&'
    if (flush_amp) begin
      if (dec_r == DEC_PCT) begin
        e = ev_add(e, CH_PCT);
      end else if (dec_r == DEC_PCT_HEX) begin
        e = ev_add(e, CH_PCT);
        e = ev_add(e, held_r);
      end
      dec_nxt = DEC_IDLE;
    end

    // percent decode of one kept value byte
    if (step_dec) begin
      if (dec_r == DEC_PCT && is_hex(in_byte)) begin
        held_nxt = in_byte;
        dec_nxt  = DEC_PCT_HEX;
      end else if (dec_r == DEC_PCT_HEX && is_hex(in_byte)) begin
        e       = ev_add(e, {hex_val(held_r), hex_val(in_byte)});
        dec_nxt = DEC_IDLE;
      end else begin
        // malformed escape passes through literally
        if (dec_r == DEC_PCT) begin
          e = ev_add(e, CH_PCT);
        end else if (dec_r == DEC_PCT_HEX) begin
          e = ev_add(e, CH_PCT);
          e = ev_add(e, held_r);
        end
        if (in_byte == CH_PCT) begin
          dec_nxt = DEC_PCT;
        end else begin
          e       = ev_add(e, (in_byte == CH_PLUS) ? CH_SPACE : in_byte);
          dec_nxt = DEC_IDLE;
        end
      end
    end

    e.found = (phase_nxt != PH_SEARCH);
    e.last  = body_end;

    // body end: flush the escape and return to the search
    if (body_end) begin
      if (dec_nxt == DEC_PCT) begin
        e = ev_add(e, CH_PCT);
      end else if (dec_nxt == DEC_PCT_HEX) begin
        e = ev_add(e, CH_PCT);
        e = ev_add(e, held_nxt);
      end
      pfx_nxt   = (MAX_KEY_LEN+1)'(1);
      phase_nxt = PH_SEARCH;
      raw_nxt   = 8'd0;
      dec_nxt   = DEC_IDLE;
      held_nxt  = 8'd0;
    end
  end

  assign ev      = e;
  assign ev_push = acc && ((e.cnt != '0) || body_end);

  // configuration and body state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r   <= 6'd0;
      key_chars_r <= '0;
      limit_r     <= VALUE_LIMIT_RST;
      pfx_r       <= (MAX_KEY_LEN+1)'(1);
      phase_r     <= PH_SEARCH;
      raw_r       <= 8'd0;
      dec_r       <= DEC_IDLE;
      held_r      <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_KEY_LENGTH:  key_len_r <= cfg_wdata[5:0];
          REG_KEY_CHARS_0: key_chars_r[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
          REG_KEY_CHARS_1: key_chars_r[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
          REG_KEY_CHARS_2: key_chars_r[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
          REG_KEY_CHARS_3: key_chars_r[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
          REG_VALUE_LIMIT: limit_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (acc) begin
        pfx_r   <= pfx_nxt;
        phase_r <= phase_nxt;
        raw_r   <= raw_nxt;
        dec_r   <= dec_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule

### rtl/core/ffx_queue.sv
// ----------------------------------------------------------------------------
// ffx_queue
// Short queue of decoded-byte entries between the front and the back.
// ----------------------------------------------------------------------------
module ffx_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ffx_pkg::ffx_ev_t  push_ev,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output ffx_pkg::ffx_ev_t  head
);
  import ffx_pkg::*;

  ffx_ev_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_ev;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

### rtl/core/ffx_back.sv
// ----------------------------------------------------------------------------
// ffx_back
// Takes queue entries apart into result words, one word per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ffx_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ffx_pkg::ffx_ev_t  head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast,
  output logic [1:0]        out_tuser
);
  import ffx_pkg::*;

  logic [EMIT_CNT_W-1:0] sub_r, sub_nxt;
  logic                  vld_r;
  logic [7:0]            data_r;
  logic                  last_r;
  logic [1:0]            user_r;

  logic                  load;
  logic                  fin;
  logic [EMIT_CNT_W-1:0] words;

  // an entry with no bytes is a single end-of-body word
  assign words = (head.cnt == '0) ? EMIT_CNT_W'(1) : head.cnt;
  assign fin   = (sub_r == words - EMIT_CNT_W'(1));
  assign load  = !q_empty && (!vld_r || out_tready);
  assign pop   = load && fin;

  always_comb begin
    sub_nxt = sub_r;
    if (load) begin
      sub_nxt = fin ? '0 : sub_r + EMIT_CNT_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sub_r <= '0;
    end else begin
      sub_r <= sub_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r    <= (head.cnt == '0) ? 8'd0 : head.byt[sub_r[1:0]];
      last_r    <= fin && head.last;
      user_r[0] <= (head.cnt != '0);
      user_r[1] <= fin && head.last && head.found;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

endmodule

### rtl/core/ffx_checker.sv
// ----------------------------------------------------------------------------
// ffx_checker
// Port-level checks on the form field extractor, bound to the top level.
// ----------------------------------------------------------------------------
module ffx_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [7:0]                      out_tdata,
  input logic                            out_tlast,
  input logic [1:0]                      out_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed under stall");

  // found only on the final word of a body
  a_found_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("found set on a non-final word");

  // a word without a byte is the final one and carries zero
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == 8'd0))
    else $error("empty word not final or not zero");

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind form_field_extract_url_decode ffx_checker u_ffx_checker (.*);
